@@ sv/tsd_pkg.sv @@
package tsd_pkg;

    // Readings above this value are out of the sensor's range.
    localparam logic [15:0] SensorLimit = 16'd64000;

    // Added after the Celsius to Fahrenheit scaling, in tenths.
    localparam logic signed [11:0] FahrOffset = 12'sd320;

    // Reciprocals scaled by 2^16, exact over the value ranges used here.
    localparam logic [13:0] Recip5  = 14'd13108;
    localparam logic [12:0] Recip10 = 13'd6554;

    // Temperature in tenths as it leaves the conversion pipeline.
    typedef struct packed {
        logic signed [11:0] shown;
        logic               fahr;
        logic               err;
    } temp_t;

    // Seven-segment pattern for one decimal digit.
    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] pattern;
        begin
            unique case (digit)
                4'd0:    pattern = 7'b1111110;
                4'd1:    pattern = 7'b0001100;
                4'd2:    pattern = 7'b0110111;
                4'd3:    pattern = 7'b0011111;
                4'd4:    pattern = 7'b1001101;
                4'd5:    pattern = 7'b1011011;
                4'd6:    pattern = 7'b1111011;
                4'd7:    pattern = 7'b0001110;
                4'd8:    pattern = 7'b1111111;
                4'd9:    pattern = 7'b1011111;
                default: pattern = 7'b0000000;
            endcase
            return pattern;
        end
    endfunction

endpackage

@@ sv/tsd_convert.sv @@
module tsd_convert (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [15:0]   sensor_reading,
    input  logic          fahr_mode,
    output logic          out_valid,
    input  logic          out_stall,
    output tsd_pkg::temp_t out_temp
);
    import tsd_pkg::*;

    // Stage one holds Celsius tenths, stage two the displayed temperature.
    logic               s1_valid_reg;
    logic signed [11:0] s1_celsius_reg;
    logic               s1_fahr_reg;
    logic               s1_err_reg;
    logic               s2_valid_reg;
    temp_t              s2_temp_reg;

    logic               adv_s2;
    logic               adv_s1;

    logic [16:0]        rounded_sum;
    logic [10:0]        tenths_raw;
    logic signed [11:0] celsius_next;
    logic               err_next;

    logic               c_neg;
    logic [11:0]        c_mag;
    logic [12:0]        c_times9;
    logic [26:0]        div5_prod;
    logic [10:0]        div5_q;
    logic signed [11:0] div5_signed;
    temp_t              temp_next;

    // A stage moves on when it is empty or its successor is moving.
    assign adv_s2   = !s2_valid_reg || !out_stall;
    assign adv_s1   = !s1_valid_reg || adv_s2;
    assign in_stall = !adv_s1;

    // Round the raw reading to tenths and remove the -50.0 C offset.
    always_comb
    begin
        rounded_sum  = {1'b0, sensor_reading} + 17'd32;
        tenths_raw   = rounded_sum[16:6];
        celsius_next = $signed({1'b0, tenths_raw}) - 12'sd500;
        err_next     = sensor_reading > SensorLimit;
    end

    // In Fahrenheit mode, scale by 9/5 on the magnitude so that the quotient truncates toward zero.
    always_comb
    begin
        c_neg       = s1_celsius_reg[11];
        c_mag       = c_neg ? 12'(-s1_celsius_reg) : 12'(s1_celsius_reg);
        c_times9    = {c_mag[9:0], 3'b000} + {3'b000, c_mag[9:0]};
        div5_prod   = 27'(c_times9) * 27'(Recip5);
        div5_q      = div5_prod[26:16];
        div5_signed = $signed({1'b0, div5_q});
        temp_next.fahr = s1_fahr_reg;
        temp_next.err  = s1_err_reg;
        if (s1_fahr_reg)
        begin
            temp_next.shown = (c_neg ? -div5_signed : div5_signed) + FahrOffset;
        end
        else
        begin
            temp_next.shown = s1_celsius_reg;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            s1_celsius_reg <= celsius_next;
            s1_fahr_reg    <= fahr_mode;
            s1_err_reg     <= err_next;
        end
        if (adv_s2)
        begin
            s2_temp_reg <= temp_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_temp  = s2_temp_reg;

endmodule

@@ sv/tsd_encode.sv @@
module tsd_encode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  tsd_pkg::temp_t in_temp,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [29:0]   display_bits,
    output logic          sensor_error
);
    import tsd_pkg::*;

    // Stage A: magnitude, tens quotient and tenths digit.
    logic        a_valid_reg;
    logic [7:0]  a_q10_reg;
    logic [3:0]  a_d0_reg;
    logic        a_neg_reg;
    logic        a_fahr_reg;
    logic        a_err_reg;
    // Stage B: hundreds quotient and ones digit.
    logic        b_valid_reg;
    logic [3:0]  b_q100_reg;
    logic [3:0]  b_d1_reg;
    logic [3:0]  b_d0_reg;
    logic        b_neg_reg;
    logic        b_fahr_reg;
    logic        b_err_reg;
    // Stage C: the output register.
    logic        c_valid_reg;
    logic [29:0] c_bits_reg;
    logic        c_err_reg;

    logic        adv_c;
    logic        adv_b;
    logic        adv_a;

    logic        neg_next;
    logic [11:0] mag12;
    logic [10:0] mag;
    logic [23:0] div10_prod;
    logic [7:0]  q10_next;
    logic [10:0] d0_wide;
    logic [20:0] div100_prod;
    logic [3:0]  q100_next;
    logic [7:0]  d1_wide;
    logic        d3_nz;
    logic [3:0]  d2;
    logic [29:0] bits_next;

    assign adv_c    = !c_valid_reg || !out_stall;
    assign adv_b    = !b_valid_reg || adv_c;
    assign adv_a    = !a_valid_reg || adv_b;
    assign in_stall = !adv_a;

    // First decimal step on the magnitude.
    always_comb
    begin
        neg_next   = in_temp.shown[11];
        mag12      = neg_next ? 12'(-in_temp.shown) : 12'(in_temp.shown);
        mag        = mag12[10:0];
        div10_prod = 24'(mag) * 24'(Recip10);
        q10_next   = div10_prod[23:16];
        d0_wide    = mag - 11'(q10_next) * 11'd10;
    end

    // Second decimal step on the tens quotient.
    always_comb
    begin
        div100_prod = 21'(a_q10_reg) * 21'(Recip10);
        q100_next   = div100_prod[19:16];
        d1_wide     = a_q10_reg - 8'(q100_next) * 8'd10;
    end

    // Last split and segment assembly; leading zeros above the ones digit are blank.
    always_comb
    begin
        d3_nz     = b_q100_reg >= 4'd10;
        d2        = d3_nz ? b_q100_reg - 4'd10 : b_q100_reg;
        bits_next = {23'd0, seg_pattern(b_d0_reg)};
        if (d3_nz)
        begin
            bits_next[28]    = b_neg_reg;
            bits_next[27:21] = seg_pattern(4'd1);
            bits_next[20:14] = seg_pattern(d2);
            bits_next[13:7]  = seg_pattern(b_d1_reg);
        end
        else if (d2 == 4'd0)
        begin
            bits_next[14]    = b_neg_reg;
            bits_next[13:7]  = seg_pattern(b_d1_reg);
        end
        else
        begin
            bits_next[21]    = b_neg_reg;
            bits_next[20:14] = seg_pattern(d2);
            bits_next[13:7]  = seg_pattern(b_d1_reg);
        end
        if (b_fahr_reg)
        begin
            bits_next[29] = 1'b1;
        end
        else
        begin
            bits_next[28] = 1'b1;
        end
        if (b_err_reg)
        begin
            bits_next = '0;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (adv_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (adv_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_q10_reg  <= q10_next;
            a_d0_reg   <= d0_wide[3:0];
            a_neg_reg  <= neg_next;
            a_fahr_reg <= in_temp.fahr;
            a_err_reg  <= in_temp.err;
        end
        if (adv_b)
        begin
            b_q100_reg <= q100_next;
            b_d1_reg   <= d1_wide[3:0];
            b_d0_reg   <= a_d0_reg;
            b_neg_reg  <= a_neg_reg;
            b_fahr_reg <= a_fahr_reg;
            b_err_reg  <= a_err_reg;
        end
        if (adv_c)
        begin
            c_bits_reg <= bits_next;
            c_err_reg  <= b_err_reg;
        end
    end

    assign out_valid    = c_valid_reg;
    assign display_bits = c_bits_reg;
    assign sensor_error = c_err_reg;

endmodule

@@ sv/thermometer_sevenseg_display_core.sv @@
// Temperature sensor to seven-segment display word.
//
// Input channel: in_valid, in_stall and sensor_reading. A request is taken at a
// rising edge with in_valid high and in_stall low. Output channel: out_valid,
// out_stall, display_bits and sensor_error, taken the same way.
// cfg_wr_en and cfg_wr_data write the Fahrenheit mode bit; change it only while
// no request is in flight.
//
// Two stages turn the reading into tenths of a degree (rounding, offset,
// Fahrenheit scaling by a reciprocal multiply), and three stages split the
// magnitude into decimal digits and build the segment word. Without a stall,
// one request per cycle is sustained, since every stage holds a single request.
//
// Reset clears all valid bits and selects Celsius. When the receiver stalls, the
// output register holds its request and earlier stages keep filling any empty
// slots; in_stall rises only once all five stages are full.
module thermometer_sevenseg_display_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sensor_reading,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [29:0] display_bits,
    output logic        sensor_error,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);
    import tsd_pkg::*;

    logic  fahrenheit_mode_reg;
    logic  mid_valid;
    logic  mid_stall;
    temp_t mid_temp;

    // Display unit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fahrenheit_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            fahrenheit_mode_reg <= cfg_wr_data;
        end
    end

    // Reading to temperature in tenths.
    tsd_convert u_convert (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sensor_reading (sensor_reading),
        .fahr_mode      (fahrenheit_mode_reg),
        .out_valid      (mid_valid),
        .out_stall      (mid_stall),
        .out_temp       (mid_temp)
    );

    // Temperature to segment word.
    tsd_encode u_encode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mid_valid),
        .in_stall     (mid_stall),
        .in_temp      (mid_temp),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .display_bits (display_bits),
        .sensor_error (sensor_error)
    );

endmodule

@@ sv/tsd_checker.sv @@
module tsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [29:0] display_bits,
    input logic        sensor_error
);

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(display_bits)
            && $stable(sensor_error))
        else $error("Stalled result changed.");

    // An out-of-range reading blanks the whole word.
    a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sensor_error |-> display_bits == 30'd0)
        else $error("Error result with a non-blank display word.");

    // A good reading carries exactly one unit flag.
    a_unit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sensor_error |-> $onehot(display_bits[29:28]))
        else $error("Display word without exactly one unit flag.");

    // Nothing is offered straight out of reset.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("Result offered straight after reset.");

endmodule

bind thermometer_sevenseg_display_core tsd_checker u_tsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .display_bits (display_bits),
    .sensor_error (sensor_error)
);
